/* rtl/core/linked_task_queue_manager_core_assert.svh */
// assertion macros used by the queue manager datapath
`ifndef LINKED_TASK_QUEUE_MANAGER_CORE_ASSERT_SVH
`define LINKED_TASK_QUEUE_MANAGER_CORE_ASSERT_SVH

// condition a implies condition b in the same cycle
`define LTQM_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ltqm assertion failed");

// condition a implies condition b in the next cycle
`define LTQM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("ltqm assertion failed");

`endif

/* rtl/core/ltqm_pkg.sv */
// shared constants, codes and control types of the linked task queue manager
package ltqm_pkg;

  localparam int NUM_TASKS  = 32;
  localparam int NUM_QUEUES = 16;
  localparam int TASK_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int QUEUE_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_UNLINK = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ERROR = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the item and read the link memories
    logic exec;     // update lists and load the result register
  } ltqm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_valid;
  } ltqm_stat_t;

endpackage

/* rtl/core/ltqm_ctrl.sv */
// controller state machine of the linked task queue manager
module ltqm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_stall,
  input  ltqm_pkg::ltqm_stat_t stat,
  output ltqm_pkg::ltqm_cmd_t  cmd
);

  ltqm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltqm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    in_stall    = 1'b1;
    case (state)
      ltqm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ltqm_pkg::S_EXEC;
        end
      end
      ltqm_pkg::S_EXEC: begin
        // wait while a finished result is still held at the output
        if (!stat.res_valid || !out_stall) begin
          cmd.exec   = 1'b1;
          state_next = ltqm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ltqm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/ltqm_dpath.sv */
// datapath of the linked task queue manager: queue table, link memories, result register
`include "linked_task_queue_manager_core_assert.svh"

module ltqm_dpath (
  input  logic                clk,
  input  logic                rst,
  input  ltqm_pkg::ltqm_cmd_t  cmd,
  output ltqm_pkg::ltqm_stat_t stat,
  input  logic [1:0]          opcode,
  input  logic [3:0]          queue_id,
  input  logic [4:0]          task_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [4:0]          removed_task,
  output logic [4:0]          head_task,
  output logic                queue_empty
);

  localparam int TW = ltqm_pkg::TASK_W;
  localparam int QW = ltqm_pkg::QUEUE_W;
  localparam int NT = ltqm_pkg::NUM_TASKS;
  localparam int NQ = ltqm_pkg::NUM_QUEUES;

  // per queue
  logic [TW-1:0] head_q [NQ];
  logic [TW-1:0] tail_q [NQ];
  logic [NQ-1:0] nonempty;

  // per task: valid bits in flops, links in memories
  logic [NT-1:0] queued;
  logic [NT-1:0] has_next;
  logic [TW-1:0] next_mem [NT];
  logic [TW-1:0] prev_mem [NT];
  logic [QW-1:0] qnum_mem [NT];

  // latched item and registered read data
  logic [1:0]    op_r;
  logic [3:0]    q_r;
  logic [4:0]    t_r;
  logic [TW-1:0] rd_next;
  logic [TW-1:0] rd_prev;
  logic [QW-1:0] rd_qnum;

  // result register
  logic          res_valid;
  logic [1:0]    res_status;
  logic [4:0]    res_removed;
  logic [4:0]    res_head;
  logic          res_empty;

  // update decisions
  logic          q_ok, t_ok;
  logic [QW-1:0] qi;
  logic [TW-1:0] ti;
  logic          ne;
  logic [TW-1:0] hd, tl;
  logic          do_pop;
  logic [TW-1:0] pop_task;
  logic [NT-1:0] queued_next, has_next_next;
  logic          hq_we, tq_we, ne_we, ne_wd;
  logic [TW-1:0] hq_wd, tq_wd;
  logic          nx_we, pv_we, qn_we;
  logic [TW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, qn_wa;
  logic [QW-1:0] qn_wd;
  ltqm_pkg::status_t st;
  logic [TW-1:0] removed;
  logic          new_ne;
  logic [TW-1:0] new_hd;
  logic [TW-1:0] rd_addr;

  // next link is read at the head for a pop, else at the given task
  assign rd_addr = (ltqm_pkg::opcode_t'(opcode) == ltqm_pkg::OP_POP)
                   ? head_q[queue_id[QW-1:0]] : task_id[TW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode;
      q_r     <= queue_id;
      t_r     <= task_id;
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[task_id[TW-1:0]];
      rd_qnum <= qnum_mem[task_id[TW-1:0]];
    end
  end

  assign qi   = q_r[QW-1:0];
  assign ti   = t_r[TW-1:0];
  assign q_ok = 32'(q_r) < NQ;
  assign t_ok = 32'(t_r) < NT;
  assign ne   = nonempty[qi];
  assign hd   = head_q[qi];
  assign tl   = tail_q[qi];

  always_comb begin
    st            = ltqm_pkg::STAT_ERROR;
    removed       = '0;
    do_pop        = 1'b0;
    pop_task      = hd;
    queued_next   = queued;
    has_next_next = has_next;
    hq_we = 1'b0;  hq_wd = ti;
    tq_we = 1'b0;  tq_wd = ti;
    ne_we = 1'b0;  ne_wd = 1'b0;
    nx_we = 1'b0;  nx_wa = tl;  nx_wd = ti;
    pv_we = 1'b0;  pv_wa = ti;  pv_wd = tl;
    qn_we = 1'b0;  qn_wa = ti;  qn_wd = qi;
    new_ne = ne;
    new_hd = hd;
    if (q_ok) begin
      case (ltqm_pkg::opcode_t'(op_r))
        ltqm_pkg::OP_APPEND: begin
          if (t_ok && !queued[ti]) begin
            if (ne) begin
              nx_we = 1'b1;
              has_next_next[tl] = 1'b1;
              pv_we = 1'b1;
              pv_wd = tl;
            end else begin
              hq_we  = 1'b1;
              hq_wd  = ti;
              pv_we  = 1'b1;
              pv_wd  = ti;
              ne_we  = 1'b1;
              ne_wd  = 1'b1;
              new_ne = 1'b1;
              new_hd = ti;
            end
            tq_we = 1'b1;
            tq_wd = ti;
            has_next_next[ti] = 1'b0;
            queued_next[ti]   = 1'b1;
            qn_we = 1'b1;
            st    = ltqm_pkg::STAT_DONE;
          end
        end
        ltqm_pkg::OP_POP: begin
          if (ne) begin
            do_pop = 1'b1;
            st     = ltqm_pkg::STAT_DONE;
          end else begin
            st = ltqm_pkg::STAT_EMPTY;
          end
        end
        ltqm_pkg::OP_UNLINK: begin
          if (t_ok && queued[ti] && rd_qnum == qi && ne) begin
            st = ltqm_pkg::STAT_DONE;
            if (hd == ti) begin
              do_pop = 1'b1;
            end else begin
              if (has_next[ti]) begin
                // splice predecessor to successor
                nx_we = 1'b1;
                nx_wa = rd_prev;
                nx_wd = rd_next;
                pv_we = 1'b1;
                pv_wa = rd_next;
                pv_wd = rd_prev;
              end else begin
                // unlinking the tail
                has_next_next[rd_prev] = 1'b0;
                tq_we = 1'b1;
                tq_wd = rd_prev;
              end
              has_next_next[ti] = 1'b0;
              queued_next[ti]   = 1'b0;
              removed = ti;
            end
          end
        end
        default: begin
          st = ltqm_pkg::STAT_ERROR;
        end
      endcase
    end
    if (do_pop) begin
      pop_task = hd;
      removed  = hd;
      if (has_next[hd]) begin
        hq_we  = 1'b1;
        hq_wd  = rd_next;
        new_hd = rd_next;
      end else begin
        ne_we  = 1'b1;
        ne_wd  = 1'b0;
        hq_we  = 1'b1;
        hq_wd  = '0;
        tq_we  = 1'b1;
        tq_wd  = '0;
        new_ne = 1'b0;
      end
      has_next_next[pop_task] = 1'b0;
      queued_next[pop_task]   = 1'b0;
    end
    if (!q_ok) begin
      new_ne = 1'b0;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
      queued   <= '0;
      has_next <= '0;
    end else if (cmd.exec) begin
      if (ne_we) begin
        nonempty[qi] <= ne_wd;
      end
      queued   <= queued_next;
      has_next <= has_next_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (hq_we) begin
        head_q[qi] <= hq_wd;
      end
      if (tq_we) begin
        tail_q[qi] <= tq_wd;
      end
      if (nx_we) begin
        next_mem[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
        prev_mem[pv_wa] <= pv_wd;
      end
      if (qn_we) begin
        qnum_mem[qn_wa] <= qn_wd;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.exec) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status  <= st;
      res_removed <= 5'(removed);
      res_head    <= new_ne ? 5'(new_hd) : 5'd0;
      res_empty   <= !new_ne;
    end
  end

  assign stat.res_valid = res_valid;
  assign out_valid      = res_valid;
  assign status         = res_status;
  assign removed_task   = res_removed;
  assign head_task      = res_head;
  assign queue_empty    = res_empty;

  `LTQM_ASSERT_SAME(a_next_only_if_queued, clk, rst, 1'b1, (has_next & ~queued) == '0)
  `LTQM_ASSERT_NEXT(a_exec_gives_result, clk, rst, cmd.exec, res_valid)
  `LTQM_ASSERT_SAME(a_empty_head_zero, clk, rst, res_valid && res_empty, res_head == 5'd0)
  `LTQM_ASSERT_SAME(a_no_exec_over_held, clk, rst, cmd.exec, !res_valid || !out_stall)

endmodule

/* rtl/core/linked_task_queue_manager_core.sv */
// Linked task queue manager: sixteen FIFO queues kept as doubly linked lists over
// thirty-two task numbers. Each item appends a task at a queue's tail, removes the
// head, or unlinks a given task, and gives one result with status, removed task and
// the queue's head and empty flag afterwards. Each item is first captured, reading the
// next, previous and queue-number link memories into registers, then executed, which
// updates the lists and loads the output register; the next item is accepted the cycle
// after that update. A result held by out_stall delays the update of the following
// item until the output register frees. No clearing pass after reset.
module linked_task_queue_manager_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [3:0] queue_id,
  input  logic [4:0] task_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [4:0] removed_task,
  output logic [4:0] head_task,
  output logic       queue_empty
);

  ltqm_pkg::ltqm_cmd_t  cmd;
  ltqm_pkg::ltqm_stat_t stat;

  ltqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ltqm_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .queue_id     (queue_id),
    .task_id      (task_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .removed_task (removed_task),
    .head_task    (head_task),
    .queue_empty  (queue_empty)
  );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the linked task queue manager core
`timescale 1ns / 100ps
module tb_top;

  localparam int TW = ltqm_pkg::TASK_W;
  localparam int QW = ltqm_pkg::QUEUE_W;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICT = 1'b0;
  localparam int RANDOM_ITEMS = 850;

  typedef struct packed {
    ltqm_pkg::status_t st;
    logic [TW-1:0]     rem;
    logic [TW-1:0]     head;
    logic              empty;
  } qresult_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [QW-1:0] q;
    logic [TW-1:0] t;
    logic          typed_in;
    logic [1:0]    st;
    logic [TW-1:0] rem;
    logic [TW-1:0] head;
    logic          empty;
  } step_row_t;

  // op, queue, task, typed, then status, removed, head, empty when typed
  localparam step_row_t SCRIPT [23] = '{
    {ltqm_pkg::OP_POP, 4'd0, 5'd0, TYPED, ltqm_pkg::STAT_EMPTY, 5'd0, 5'd0, 1'b1},
    {ltqm_pkg::OP_UNLINK, 4'd15, 5'd31, TYPED, ltqm_pkg::STAT_ERROR, 5'd0, 5'd0, 1'b1},
    {OP_UNUSED, 4'd0, 5'd0, TYPED, ltqm_pkg::STAT_ERROR, 5'd0, 5'd0, 1'b1},
    {ltqm_pkg::OP_APPEND, 4'd0, 5'd0, TYPED, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_APPEND, 4'd0, 5'd31, TYPED, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_APPEND, 4'd15, 5'd0, TYPED, ltqm_pkg::STAT_ERROR, 5'd0, 5'd0, 1'b1},
    {ltqm_pkg::OP_APPEND, 4'd15, 5'd15, TYPED, ltqm_pkg::STAT_DONE, 5'd0, 5'd15, 1'b0},
    {ltqm_pkg::OP_APPEND, 4'd15, 5'd31, TYPED, ltqm_pkg::STAT_ERROR, 5'd0, 5'd15, 1'b0},
    {ltqm_pkg::OP_APPEND, 4'd0, 5'd7, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_UNLINK, 4'd15, 5'd7, TYPED, ltqm_pkg::STAT_ERROR, 5'd0, 5'd15, 1'b0},
    {ltqm_pkg::OP_UNLINK, 4'd0, 5'd31, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_UNLINK, 4'd0, 5'd7, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_APPEND, 4'd0, 5'd20, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_APPEND, 4'd0, 5'd21, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_UNLINK, 4'd0, 5'd0, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_UNLINK, 4'd0, 5'd0, TYPED, ltqm_pkg::STAT_ERROR, 5'd0, 5'd20, 1'b0},
    {ltqm_pkg::OP_POP, 4'd0, 5'd31, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_POP, 4'd0, 5'd0, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_POP, 4'd0, 5'd0, TYPED, ltqm_pkg::STAT_EMPTY, 5'd0, 5'd0, 1'b1},
    {ltqm_pkg::OP_POP, 4'd15, 5'd0, TYPED, ltqm_pkg::STAT_DONE, 5'd15, 5'd0, 1'b1},
    {OP_UNUSED, 4'd15, 5'd31, TYPED, ltqm_pkg::STAT_ERROR, 5'd0, 5'd0, 1'b1},
    {ltqm_pkg::OP_APPEND, 4'd8, 5'd16, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0},
    {ltqm_pkg::OP_UNLINK, 4'd8, 5'd16, PREDICT, ltqm_pkg::STAT_DONE, 5'd0, 5'd0, 1'b0}
  };

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    opcode = '0;
  logic [QW-1:0] queue_id = '0;
  logic [TW-1:0] task_id = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    status;
  logic [TW-1:0] removed_task;
  logic [TW-1:0] head_task;
  logic          queue_empty;

  // mirror of the list state
  bit [TW-1:0] q_head [ltqm_pkg::NUM_QUEUES];
  bit [TW-1:0] q_tail [ltqm_pkg::NUM_QUEUES];
  bit          q_live [ltqm_pkg::NUM_QUEUES];
  bit [TW-1:0] link_next [ltqm_pkg::NUM_TASKS];
  bit          link_has_next [ltqm_pkg::NUM_TASKS];
  bit [TW-1:0] link_prev [ltqm_pkg::NUM_TASKS];
  bit          task_held [ltqm_pkg::NUM_TASKS];
  bit [QW-1:0] task_owner [ltqm_pkg::NUM_TASKS];

  qresult_t pending_results [$];
  int mismatches = 0;
  int in_max_gap = 0;
  int out_max_gap = 0;

  always #10 clk = ~clk;

  linked_task_queue_manager_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .queue_id     (queue_id),
    .task_id      (task_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .removed_task (removed_task),
    .head_task    (head_task),
    .queue_empty  (queue_empty)
  );

  function automatic logic [TW-1:0] take_head(logic [QW-1:0] q);
    logic [TW-1:0] top;
    top = q_head[q];
    if (link_has_next[top]) begin
      q_head[q] = link_next[top];
    end else begin
      q_live[q] = 1'b0;
      q_head[q] = '0;
      q_tail[q] = '0;
    end
    link_has_next[top] = 1'b0;
    task_held[top] = 1'b0;
    return top;
  endfunction

  function automatic qresult_t apply_queue_op(logic [1:0] op, logic [QW-1:0] q,
                                              logic [TW-1:0] t);
    qresult_t r;
    logic [TW-1:0] p;
    logic [TW-1:0] n;
    r.st = ltqm_pkg::STAT_ERROR;
    r.rem = '0;
    case (op)
      ltqm_pkg::OP_APPEND: begin
        if (!task_held[t]) begin
          if (q_live[q]) begin
            link_next[q_tail[q]] = t;
            link_has_next[q_tail[q]] = 1'b1;
            link_prev[t] = q_tail[q];
          end else begin
            q_head[q] = t;
            link_prev[t] = t;
            q_live[q] = 1'b1;
          end
          q_tail[q] = t;
          link_has_next[t] = 1'b0;
          task_held[t] = 1'b1;
          task_owner[t] = q;
          r.st = ltqm_pkg::STAT_DONE;
        end
      end
      ltqm_pkg::OP_POP: begin
        if (q_live[q]) begin
          r.rem = take_head(q);
          r.st = ltqm_pkg::STAT_DONE;
        end else begin
          r.st = ltqm_pkg::STAT_EMPTY;
        end
      end
      ltqm_pkg::OP_UNLINK: begin
        if (task_held[t] && task_owner[t] == q && q_live[q]) begin
          if (q_head[q] == t) begin
            r.rem = take_head(q);
          end else begin
            p = link_prev[t];
            if (link_has_next[t]) begin
              n = link_next[t];
              link_next[p] = n;
              link_prev[n] = p;
            end else begin
              // unlinking the tail
              link_has_next[p] = 1'b0;
              link_next[p] = '0;
              q_tail[q] = p;
            end
            link_has_next[t] = 1'b0;
            task_held[t] = 1'b0;
            r.rem = t;
          end
          r.st = ltqm_pkg::STAT_DONE;
        end
      end
      default: ;
    endcase
    r.head = q_live[q] ? q_head[q] : '0;
    r.empty = !q_live[q];
    return r;
  endfunction

  function automatic int pick_max_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 19;
    endcase
  endfunction

  function automatic void check_field(string name, logic [4:0] want, logic [4:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic send_item(logic [1:0] op, logic [QW-1:0] q, logic [TW-1:0] t,
                           bit typed_in, qresult_t typed_res);
    int gap;
    qresult_t predicted;
    gap = int'($urandom_range(0, in_max_gap));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    queue_id <= q;
    task_id <= t;
    // stall is stable from the falling edge up to the accepting edge
    do @(negedge clk); while (in_stall !== 1'b0);
    predicted = apply_queue_op(op, q, t);
    pending_results.push_back(typed_in ? typed_res : predicted);
    @(posedge clk);
  endtask

  initial begin : stimulus
    step_row_t row;
    qresult_t typed_res;
    logic [1:0] op;
    logic [QW-1:0] q;
    logic [TW-1:0] t;
    int kind;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    in_max_gap = pick_max_gap();
    foreach (SCRIPT[i]) begin
      row = SCRIPT[i];
      typed_res = '{ltqm_pkg::status_t'(row.st), row.rem, row.head, row.empty};
      send_item(row.op, row.q, row.t, row.typed_in, typed_res);
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) in_max_gap = pick_max_gap();
      kind = int'($urandom_range(0, 99));
      op = 2'($urandom_range(0, 3));
      q = QW'($urandom);
      t = TW'($urandom);
      if (kind < 40) begin
        op = ltqm_pkg::OP_APPEND;
        // crowd a few queues so that lists grow long
        if ($urandom_range(0, 3) != 0) q = QW'($urandom_range(0, 3));
        repeat (8) if (task_held[t]) t = TW'($urandom);
      end else if (kind < 65) begin
        op = ltqm_pkg::OP_POP;
        repeat (8) if (!task_held[t]) t = TW'($urandom);
        if (task_held[t] && $urandom_range(0, 4) != 0) q = task_owner[t];
      end else if (kind < 90) begin
        op = ltqm_pkg::OP_UNLINK;
        repeat (8) if (!task_held[t]) t = TW'($urandom);
        if (task_held[t] && $urandom_range(0, 9) != 0) q = task_owner[t];
      end
      send_item(op, q, t, PREDICT, '0);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : drain
    int stall_n;
    int taken;
    qresult_t want;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 40 == 0) out_max_gap = pick_max_gap();
      stall_n = int'($urandom_range(0, out_max_gap));
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: status %0d removed %0d head %0d empty %0d",
                   status, removed_task, head_task, queue_empty);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 5'(want.st), 5'(status));
        check_field("removed_task", 5'(want.rem), 5'(removed_task));
        check_field("head_task", 5'(want.head), 5'(head_task));
        check_field("queue_empty", 5'(want.empty), 5'(queue_empty));
      end
      taken++;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
